/* hw/rtl/mspt_pkg.sv */
// ============================================================================
// mspt_pkg: shared types and constants for the strong probable-prime tester
// Holds word widths, state and destination codes, and the cell weight codes.
// ============================================================================
package mspt_pkg;

    localparam int WORD_BITS = 64;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int Q_BITS    = 63;
    localparam int K_BITS    = 6;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [HALF_BITS-1:0] half_t;
    typedef logic [PROD_BITS-1:0] prod_t;

    // Weight of one partial product inside the full product.
    typedef enum logic [1:0] {
        WT_LO,
        WT_MID,
        WT_HI
    } weight_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POW,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_FIX,
        ST_AFTER,
        ST_ROUND,
        ST_DONE
    } state_t;

    // Where a finished Montgomery product goes.
    typedef enum logic [1:0] {
        DST_SQ,
        DST_MUL,
        DST_RND
    } dest_t;

endpackage

/* hw/rtl/mspt_cell.sv */
// ============================================================================
// mspt_cell: one cell of the multiplier chain
// Registers a half-word partial product and adds it, at its weight, to the
// running sum handed over by the previous cell.
// ============================================================================
module mspt_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             valid_in,
    input  mspt_pkg::half_t  a_half,
    input  mspt_pkg::half_t  b_half,
    input  mspt_pkg::weight_t weight,
    input  mspt_pkg::prod_t  sum_in,
    output logic             valid_out,
    output mspt_pkg::prod_t  sum_out
);

    mspt_pkg::word_t pp_reg;
    mspt_pkg::prod_t sum_reg;
    mspt_pkg::prod_t sum_next;
    mspt_pkg::prod_t shifted;
    logic            valid_reg;

    always_comb begin
        case (weight)
            mspt_pkg::WT_LO:  shifted = mspt_pkg::PROD_BITS'(pp_reg);
            mspt_pkg::WT_MID: shifted = mspt_pkg::PROD_BITS'(pp_reg) << mspt_pkg::HALF_BITS;
            mspt_pkg::WT_HI:  shifted = mspt_pkg::PROD_BITS'(pp_reg) << mspt_pkg::WORD_BITS;
            default:          shifted = '0;
        endcase
        sum_next = sum_in + shifted;
    end

    always_ff @(posedge aclk) begin
        pp_reg  <= a_half * b_half;
        sum_reg <= sum_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_in;
        end
    end

    assign valid_out = valid_reg;
    assign sum_out   = sum_reg;

endmodule

/* hw/rtl/mspt_mul.sv */
// ============================================================================
// mspt_mul: full-width multiplier built from a chain of four cells
// Operands must stay steady from start until done; the start pulse passes
// a delay register and then the four cells before done rises.
// ============================================================================
module mspt_mul (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  mspt_pkg::word_t op_a,
    input  mspt_pkg::word_t op_b,
    output logic            done,
    output mspt_pkg::prod_t prod
);

    logic            start_d_reg;
    logic            v0, v1, v2;
    mspt_pkg::prod_t s0, s1, s2;
    mspt_pkg::half_t a_lo, a_hi, b_lo, b_hi;

    assign a_lo = op_a[mspt_pkg::HALF_BITS-1:0];
    assign a_hi = op_a[mspt_pkg::WORD_BITS-1:mspt_pkg::HALF_BITS];
    assign b_lo = op_b[mspt_pkg::HALF_BITS-1:0];
    assign b_hi = op_b[mspt_pkg::WORD_BITS-1:mspt_pkg::HALF_BITS];

    // The partial products are registered and settle in the cycle after start, so the sum enters late.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_d_reg <= 1'b0;
        end else begin
            start_d_reg <= start;
        end
    end

    mspt_cell u_cell0 (
        .aclk(aclk), .aresetn(aresetn), .valid_in(start_d_reg),
        .a_half(a_lo), .b_half(b_lo), .weight(mspt_pkg::WT_LO),
        .sum_in('0), .valid_out(v0), .sum_out(s0)
    );
    mspt_cell u_cell1 (
        .aclk(aclk), .aresetn(aresetn), .valid_in(v0),
        .a_half(a_lo), .b_half(b_hi), .weight(mspt_pkg::WT_MID),
        .sum_in(s0), .valid_out(v1), .sum_out(s1)
    );
    mspt_cell u_cell2 (
        .aclk(aclk), .aresetn(aresetn), .valid_in(v1),
        .a_half(a_hi), .b_half(b_lo), .weight(mspt_pkg::WT_MID),
        .sum_in(s1), .valid_out(v2), .sum_out(s2)
    );
    mspt_cell u_cell3 (
        .aclk(aclk), .aresetn(aresetn), .valid_in(v2),
        .a_half(a_hi), .b_half(b_hi), .weight(mspt_pkg::WT_HI),
        .sum_in(s2), .valid_out(done), .sum_out(prod)
    );

endmodule

/* hw/rtl/montgomery_strong_prime_test_unit.sv */
// ============================================================================
// montgomery_strong_prime_test_unit: strong probable-prime test, one base
// Montgomery exponentiation followed by repeated squaring on one shared
// REDC datapath built around a chained multiplier.
// ============================================================================
//  Channel  | Direction | Contents
//  s_       | in        | one test request (modulus, inverse, base, q, k, one)
//  m_       | out       | one verdict bit per request
//
// Each Montgomery product takes three passes through the cell-chain
// multiplier, then a subtract state and a dispatch state. A squaring
// also passes through the state that launches it, ST_POW or ST_ROUND,
// which the multiply after a squaring skips.
// One request is worked at a time; a new one is taken once the verdict
// has moved to the output register. A stalled output holds the block in
// its final state. Reset is synchronous and clears the state register, the
// multiplier start and valid flags, and the output valid flag.
module montgomery_strong_prime_test_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // n_value[63:0], n_inverse[127:64], base_redc[191:128], odd_part[254:192],
    // two_power[260:255], one_redc[324:261], zero fill to 328 bits.
    input  logic [327:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // probably_prime[0], zero fill to 8 bits.
    output logic [7:0]   m_tdata
);

    mspt_pkg::state_t state_reg, state_next;
    mspt_pkg::dest_t  dst_reg, dst_next;
    mspt_pkg::word_t  n_reg, n_next;
    mspt_pkg::word_t  ni_reg, ni_next;
    mspt_pkg::word_t  one_reg, one_next;
    mspt_pkg::word_t  mo_reg, mo_next;
    mspt_pkg::word_t  sq_reg, sq_next;
    mspt_pkg::word_t  acc_reg, acc_next;
    mspt_pkg::word_t  rh_reg, rh_next;
    mspt_pkg::word_t  th_reg, th_next;
    mspt_pkg::word_t  op_a_reg, op_a_next;
    mspt_pkg::word_t  op_b_reg, op_b_next;
    logic [mspt_pkg::Q_BITS-1:0] exp_reg, exp_next;
    logic [mspt_pkg::K_BITS-1:0] k_reg, k_next;
    logic [mspt_pkg::K_BITS-1:0] rnd_reg, rnd_next;
    logic             start_reg, start_next;
    logic             pass_reg, pass_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_bit_reg, out_bit_next;

    logic             mul_done;
    mspt_pkg::prod_t  prod;
    mspt_pkg::word_t  diff, redc_x;
    mspt_pkg::word_t  in_n, in_ni, in_b, in_one;
    logic [mspt_pkg::Q_BITS-1:0] in_q;
    logic [mspt_pkg::K_BITS-1:0] in_k;

    assign in_n   = s_tdata[0 +: mspt_pkg::WORD_BITS];
    assign in_ni  = s_tdata[64 +: mspt_pkg::WORD_BITS];
    assign in_b   = s_tdata[128 +: mspt_pkg::WORD_BITS];
    assign in_q   = s_tdata[254:192];
    assign in_k   = s_tdata[260:255];
    assign in_one = s_tdata[261 +: mspt_pkg::WORD_BITS];

    mspt_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .op_a(op_a_reg), .op_b(op_b_reg), .done(mul_done), .prod(prod)
    );

    assign diff   = rh_reg - th_reg;
    assign redc_x = (rh_reg < th_reg) ? (diff + n_reg) : diff;

    assign s_tready = (state_reg == mspt_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_bit_reg};

    always_comb begin
        state_next     = state_reg;
        dst_next       = dst_reg;
        n_next         = n_reg;
        ni_next        = ni_reg;
        one_next       = one_reg;
        mo_next        = mo_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        rh_next        = rh_reg;
        th_next        = th_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        exp_next       = exp_reg;
        k_next         = k_reg;
        rnd_next       = rnd_reg;
        start_next     = 1'b0;
        pass_next      = pass_reg;
        out_bit_next   = out_bit_reg;
        out_valid_next = out_valid_reg && !m_tready;

        case (state_reg)
            mspt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_next     = in_n;
                    ni_next    = in_ni;
                    one_next   = in_one;
                    mo_next    = in_n - in_one;
                    sq_next    = in_b;
                    exp_next   = in_q;
                    k_next     = in_k;
                    acc_next   = in_q[0] ? in_b : in_one;
                    state_next = mspt_pkg::ST_POW;
                end
            end
            mspt_pkg::ST_POW: begin
                if (exp_reg == '0) begin
                    if (acc_reg == one_reg || acc_reg == mo_reg) begin
                        pass_next  = 1'b1;
                        state_next = mspt_pkg::ST_DONE;
                    end else begin
                        rnd_next   = mspt_pkg::K_BITS'(1);
                        state_next = mspt_pkg::ST_ROUND;
                    end
                end else begin
                    op_a_next  = sq_reg;
                    op_b_next  = sq_reg;
                    start_next = 1'b1;
                    dst_next   = mspt_pkg::DST_SQ;
                    state_next = mspt_pkg::ST_M1;
                end
            end
            mspt_pkg::ST_ROUND: begin
                if (rnd_reg < k_reg) begin
                    op_a_next  = acc_reg;
                    op_b_next  = acc_reg;
                    start_next = 1'b1;
                    dst_next   = mspt_pkg::DST_RND;
                    state_next = mspt_pkg::ST_M1;
                end else begin
                    pass_next  = 1'b0;
                    state_next = mspt_pkg::ST_DONE;
                end
            end
            mspt_pkg::ST_M1: begin
                if (mul_done) begin
                    rh_next    = prod[mspt_pkg::PROD_BITS-1:mspt_pkg::WORD_BITS];
                    op_a_next  = prod[mspt_pkg::WORD_BITS-1:0];
                    op_b_next  = ni_reg;
                    start_next = 1'b1;
                    state_next = mspt_pkg::ST_M2;
                end
            end
            mspt_pkg::ST_M2: begin
                if (mul_done) begin
                    op_a_next  = prod[mspt_pkg::WORD_BITS-1:0];
                    op_b_next  = n_reg;
                    start_next = 1'b1;
                    state_next = mspt_pkg::ST_M3;
                end
            end
            mspt_pkg::ST_M3: begin
                if (mul_done) begin
                    th_next    = prod[mspt_pkg::PROD_BITS-1:mspt_pkg::WORD_BITS];
                    state_next = mspt_pkg::ST_FIX;
                end
            end
            mspt_pkg::ST_FIX: begin
                if (dst_reg == mspt_pkg::DST_SQ) begin
                    sq_next  = redc_x;
                    exp_next = exp_reg >> 1;
                end else begin
                    acc_next = redc_x;
                end
                state_next = mspt_pkg::ST_AFTER;
            end
            mspt_pkg::ST_AFTER: begin
                case (dst_reg)
                    mspt_pkg::DST_SQ: begin
                        if (exp_reg[0]) begin
                            op_a_next  = acc_reg;
                            op_b_next  = sq_reg;
                            start_next = 1'b1;
                            dst_next   = mspt_pkg::DST_MUL;
                            state_next = mspt_pkg::ST_M1;
                        end else begin
                            state_next = mspt_pkg::ST_POW;
                        end
                    end
                    mspt_pkg::DST_MUL: begin
                        state_next = mspt_pkg::ST_POW;
                    end
                    mspt_pkg::DST_RND: begin
                        if (acc_reg == mo_reg) begin
                            pass_next  = 1'b1;
                            state_next = mspt_pkg::ST_DONE;
                        end else if (acc_reg == one_reg) begin
                            pass_next  = 1'b0;
                            state_next = mspt_pkg::ST_DONE;
                        end else begin
                            rnd_next   = rnd_reg + mspt_pkg::K_BITS'(1);
                            state_next = mspt_pkg::ST_ROUND;
                        end
                    end
                    default: begin
                        state_next = mspt_pkg::ST_IDLE;
                    end
                endcase
            end
            mspt_pkg::ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_bit_next   = pass_reg;
                    state_next     = mspt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mspt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        dst_reg     <= dst_next;
        n_reg       <= n_next;
        ni_reg      <= ni_next;
        one_reg     <= one_next;
        mo_reg      <= mo_next;
        sq_reg      <= sq_next;
        acc_reg     <= acc_next;
        rh_reg      <= rh_next;
        th_reg      <= th_next;
        op_a_reg    <= op_a_next;
        op_b_reg    <= op_b_next;
        exp_reg     <= exp_next;
        k_reg       <= k_next;
        rnd_reg     <= rnd_next;
        pass_reg    <= pass_next;
        out_bit_reg <= out_bit_next;
        if (!aresetn) begin
            state_reg     <= mspt_pkg::ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A multiplier pass is only launched from a state that waits for it.
    a_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> (state_reg == mspt_pkg::ST_M1 || state_reg == mspt_pkg::ST_M2 ||
                       state_reg == mspt_pkg::ST_M3))
        else $error("multiplier started outside a product state");

    // A finished product always lands in a state that consumes it.
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == mspt_pkg::ST_M1 || state_reg == mspt_pkg::ST_M2 ||
                      state_reg == mspt_pkg::ST_M3))
        else $error("product finished with no consumer");

    // An accepted request always starts the exponentiation.
    a_accept_pow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == mspt_pkg::ST_POW))
        else $error("accepted request did not start exponentiation");

    // A new verdict only appears when the final state hands it over.
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == mspt_pkg::ST_DONE))
        else $error("verdict appeared without a finished test");

endmodule
